FILE: src/mpeg_picture_type_detector_assert.svh
// Assertion macros for the picture type detector.
// Included by the top level; needs clk and rst in scope.
`ifndef MPEG_PICTURE_TYPE_DETECTOR_ASSERT_SVH
`define MPEG_PICTURE_TYPE_DETECTOR_ASSERT_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define MPTD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent holds -> consequent holds in the next cycle.
`define MPTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mptd_pkg.sv
// Shared types and constants for the picture type detector.
// No dependencies.
package mptd_pkg;

  localparam logic [7:0] PIC_CODE   = 8'h00;
  localparam logic [7:0] VOP_CODE   = 8'hB6;
  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] BYTE_ONE   = 8'h01;
  localparam logic [1:0] ZRUN_FULL  = 2'd2;
  localparam logic [2:0] TYPE_MASK  = 3'd7;
  localparam logic [2:0] PTYPE_I    = 3'd1;
  localparam logic [2:0] PTYPE_B    = 3'd3;
  localparam logic [1:0] VOP_RSVD   = 2'd3;
  localparam logic [1:0] TYPE_NONE  = 2'd3;
  localparam logic       CODEC_MPEG4  = 1'b0;
  localparam logic       CODEC_MPEG12 = 1'b1;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_CODE   = 2'd1,
    PH_HDR1   = 2'd2,
    PH_HDR2   = 2'd3
  } phase_t;

  typedef struct packed {
    logic       emit;
    logic [1:0] kind;
  } step_res_t;

endpackage

FILE: src/mpeg_picture_type_detector.sv
// Top level of the picture type detector: input register, parser, result register.
// Depends on mptd_pkg, mptd_parser and mpeg_picture_type_detector_assert.svh.
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------
//  input   | in_valid / in_ready    | stream_byte, frame_end
//  output  | out_valid / out_ready  | frame_type
//  config  | cfg_valid / cfg_ready  | codec_family
//
// One byte per cycle sustained unless a held result stalls a byte that would emit;
// a byte's result reaches frame_type via the input register, then the result register.
// A result is emitted for the first picture type found, or on the frame's last
// byte if none was found. A held result stalls only bytes that would emit.
// Synchronous reset clears the parser state, codec_family (MPEG-4) and the valids.
`include "mpeg_picture_type_detector_assert.svh"

module mpeg_picture_type_detector
  import mptd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] stream_byte,
  input  logic       frame_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] frame_type,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       codec_family
);

  logic       codec_sel;
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_last;
  logic       advance;
  step_res_t  res;

  mptd_parser u_parser (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .data  (hold_byte),
    .last  (hold_last),
    .codec (codec_sel),
    .res   (res)
  );

  // Bytes with no result pass even while a result waits.
  assign advance   = hold_valid && (!res.emit || !out_valid || out_ready);
  assign in_ready  = !hold_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      codec_sel <= CODEC_MPEG4;
    end else if (cfg_valid) begin
      codec_sel <= codec_family;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_byte <= stream_byte;
      hold_last <= frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      frame_type <= res.kind;
    end
  end

  `MPTD_ASSERT_SAME(a_stall_cause, hold_valid && !in_ready, out_valid && !out_ready, "input stalled without a blocked result")
  `MPTD_ASSERT_NEXT(a_result_loaded, advance && res.emit, out_valid && frame_type == $past(res.kind), "emitted result not loaded")
  `MPTD_ASSERT_SAME(a_none_on_last, advance && res.emit && res.kind == TYPE_NONE, hold_last, "error result before frame end")

endmodule

FILE: src/mptd_parser.sv
// Start code scanner and picture header parser: per-frame state and step logic.
// Depends on mptd_pkg.
module mptd_parser
  import mptd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  logic [7:0] data,
  input  logic      last,
  input  logic      codec,
  output step_res_t res
);

  logic [1:0] zero_run, zero_run_next;
  phase_t     phase, phase_next;
  logic       decided;
  logic       found;
  logic [1:0] kind;
  logic [2:0] pic_type;

  assign pic_type = (data[5:3] & TYPE_MASK);

  always_comb begin
    zero_run_next = zero_run;
    phase_next    = phase;
    found         = 1'b0;
    kind          = 2'd0;
    if (!decided) begin
      unique case (phase)
        PH_SEARCH: begin
          if (data == BYTE_ZERO) begin
            if (zero_run != ZRUN_FULL) zero_run_next = zero_run + 2'd1;
          end else begin
            if (data == BYTE_ONE && zero_run == ZRUN_FULL) phase_next = PH_CODE;
            zero_run_next = 2'd0;
          end
        end
        PH_CODE: begin
          zero_run_next = 2'd0;
          if (codec == CODEC_MPEG12) begin
            phase_next = (data == PIC_CODE) ? PH_HDR1 : PH_SEARCH;
          end else begin
            phase_next = (data == VOP_CODE) ? PH_HDR1 : PH_SEARCH;
          end
        end
        PH_HDR1: begin
          if (codec == CODEC_MPEG12) begin
            phase_next = PH_HDR2;
          end else begin
            if (data[7:6] != VOP_RSVD) begin
              found = 1'b1;
              kind  = data[7:6];
            end
            phase_next    = PH_SEARCH;
            zero_run_next = 2'd0;
          end
        end
        PH_HDR2: begin
          if (pic_type >= PTYPE_I && pic_type <= PTYPE_B) begin
            found = 1'b1;
            kind  = pic_type[1:0] - 2'd1;
          end
          phase_next    = PH_SEARCH;
          zero_run_next = 2'd0;
        end
        default: phase_next = PH_SEARCH;
      endcase
    end
    res.emit = !decided && (found || last);
    res.kind = found ? kind : TYPE_NONE;
  end

  // Last byte of a frame clears the per-frame state.
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run <= 2'd0;
      phase    <= PH_SEARCH;
      decided  <= 1'b0;
    end else if (step) begin
      if (last) begin
        zero_run <= 2'd0;
        phase    <= PH_SEARCH;
        decided  <= 1'b0;
      end else begin
        zero_run <= zero_run_next;
        phase    <= phase_next;
        decided  <= decided | found;
      end
    end
  end

endmodule
